@@ rtl/assembly_language_tokenizer_defines.svh @@
// assertion macros for the assembly language tokenizer
`ifndef ASSEMBLY_LANGUAGE_TOKENIZER_DEFINES_SVH
`define ASSEMBLY_LANGUAGE_TOKENIZER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define ALT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ALT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/alt_pkg.sv @@
// package with token codes, scanner phases and keyword table
package alt_pkg;

  localparam int unsigned OffsetBits = 32;
  localparam int unsigned NumKeywords = 35;
  localparam int unsigned KwWidth = 24;

  typedef logic [OffsetBits-1:0] ofs_t;
  typedef logic [NumKeywords-1:0] kw_mask_t;

  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_END = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  localparam logic [5:0] T_END = 6'd0;
  localparam logic [5:0] T_SPACES = 6'd1;
  localparam logic [5:0] T_EOL = 6'd2;
  localparam logic [5:0] T_EQ = 6'd3;
  localparam logic [5:0] T_PERIOD = 6'd4;
  localparam logic [5:0] T_COLON = 6'd5;
  localparam logic [5:0] T_COMMA = 6'd6;
  localparam logic [5:0] T_LCURLY = 6'd7;
  localparam logic [5:0] T_RCURLY = 6'd8;
  localparam logic [5:0] T_LPAREN = 6'd9;
  localparam logic [5:0] T_RPAREN = 6'd10;
  localparam logic [5:0] T_STRING = 6'd11;
  localparam logic [5:0] T_REG = 6'd12;
  localparam logic [5:0] T_NAME = 6'd13;
  localparam logic [5:0] T_INT = 6'd14;
  localparam logic [5:0] T_REAL = 6'd15;
  localparam logic [5:0] T_SLC = 6'd16;
  localparam logic [5:0] T_MLC = 6'd17;
  localparam logic [5:0] T_ERR = 6'd18;
  localparam logic [5:0] T_KW0 = 6'd19;

  typedef enum logic [4:0] {
    P_IDLE, P_SPACES, P_CR, P_STR, P_STR_ESC, P_REG_DOLLAR, P_REG_DIGITS,
    P_REG_NAME, P_NAME, P_INT, P_FRAC, P_EXP_MARK, P_EXP_SIGN, P_EXP_DIGITS,
    P_SLASH, P_ML_BODY, P_ML_STAR, P_SL_BODY
  } phase_t;

  typedef struct packed {
    logic [5:0] token_type;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic last;
  } tok_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned p);
    string s;
    s = "";
    unique case (k)
      0: s = "class"; 1: s = "constructor"; 2: s = "enumeration"; 3: s = "entry";
      4: s = "extends"; 5: s = "implements"; 6: s = "method"; 7: s = "module";
      8: s = "procedure"; 9: s = "native"; 10: s = "return"; 11: s = "variable";
      12: s = "jump"; 13: s = "jumpIfTrue"; 14: s = "jumpIfFalse"; 15: s = "raise";
      16: s = "add"; 17: s = "subtract"; 18: s = "multiply"; 19: s = "divide";
      20: s = "negate"; 21: s = "not"; 22: s = "and"; 23: s = "or";
      24: s = "isEqualTo"; 25: s = "isNotEqualTo"; 26: s = "isLowerThan";
      27: s = "isLowerThanOrEqualTo"; 28: s = "isGreaterThan";
      29: s = "isGreaterThanOrEqualTo"; 30: s = "concatenate"; 31: s = "set";
      32: s = "void"; 33: s = "true"; 34: s = "false";
      default: s = "";
    endcase
    if (p < s.len()) begin
      return s[p];
    end
    return 8'd0;
  endfunction

  function automatic logic [2:0] utf8_bytes(input logic [20:0] c);
    if (c < 21'h80) return 3'd1;
    if (c < 21'h800) return 3'd2;
    if (c < 21'h10000) return 3'd3;
    return 3'd4;
  endfunction

endpackage

@@ rtl/alt_if.sv @@
// valid/ready channel interfaces for input and result items
interface alt_in_if;
  import alt_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [20:0] code_point;
  modport source (output valid, mode, code_point, input ready);
  modport sink (input valid, mode, code_point, output ready);
endinterface

interface alt_out_if;
  import alt_pkg::*;
  logic valid;
  logic ready;
  logic [5:0] token_type;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic last;
  modport source (output valid, token_type, token_start, token_length, last, input ready);
  modport sink (input valid, token_type, token_start, token_length, last, output ready);
endinterface

@@ rtl/assembly_language_tokenizer.sv @@
// assembly language tokenizer: one code point per cycle while in_ch.ready is high, up to two tokens per item
// an item's tokens are registered into the result register when the item is accepted
// throughput: one item per cycle while the output takes each result; a two-token item holds
// in_ch.ready low until its first token is taken, the two-entry result register draining one per cycle
// reset (rst, synchronous, active high) clears scanner state and empties the results
module assembly_language_tokenizer
  import alt_pkg::*;
(
  input logic clk,
  input logic rst,
  alt_in_if.sink in_ch,
  alt_out_if.source out_ch
);
  `include "assembly_language_tokenizer_defines.svh"

  phase_t phase, phase_next;
  kw_mask_t cand, cand_next;
  logic [4:0] npos, npos_next;
  ofs_t cstart, cstart_next, clen, clen_next;
  logic halted, halted_next;

  tok_t r0, r1, e0, e1;
  logic v0, v1;
  logic [1:0] n;

  logic [20:0] c;
  logic [2:0] b;
  logic dg, al, ns, nc;
  kw_mask_t kw_adv, kw_st;
  logic [5:0] kw_type, kw_unused;
  logic acc;

  alt_kw_match u_adv (.cand(cand), .pos(npos), .c(c), .cand_next(kw_adv),
                      .kw_type(kw_type));
  alt_kw_match u_st (.cand({NumKeywords{1'b1}}), .pos(5'd0), .c(c),
                     .cand_next(kw_st), .kw_type(kw_unused));

  assign c = in_ch.code_point;
  assign b = utf8_bytes(c);
  assign dg = c >= 21'h30 && c <= 21'h39;
  assign al = (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
  assign ns = al || c == 21'h5F;
  assign nc = ns || dg;

  // ready when result register will be empty after this edge
  assign in_ch.ready = !v0 || (out_ch.ready && !v1);
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_t p;
    ofs_t s, l;
    logic [5:0] bt;
    logic bok, used, fin, err;
    logic [5:0] ft;
    p = phase;
    s = cstart;
    l = clen;
    phase_next = phase;
    cand_next = cand;
    npos_next = npos;
    halted_next = halted;
    n = 2'd0;
    e0 = '0;
    e1 = '0;
    used = 1'b0;
    fin = 1'b0;
    err = 1'b0;
    ft = T_ERR;
    bok = 1'b1;
    bt = T_ERR;
    unique case (phase)
      P_SPACES: bt = T_SPACES;
      P_CR: bt = T_EOL;
      P_REG_DIGITS, P_REG_NAME: bt = T_REG;
      P_NAME: bt = kw_type;
      P_INT: bt = T_INT;
      P_FRAC, P_EXP_DIGITS: bt = T_REAL;
      P_SL_BODY: bt = T_SLC;
      default: bok = 1'b0;
    endcase

    if (in_ch.mode == MODE_RESTART) begin
      phase_next = P_IDLE;
      cand_next = '1;
      npos_next = '0;
      cstart_next = '0;
      clen_next = '0;
      halted_next = 1'b0;
    end else begin
      cstart_next = cstart;
      clen_next = clen;
      if (in_ch.mode == MODE_END && !halted) begin
        if (phase != P_IDLE && !bok) begin
          n = 2'd1;
          e0 = '{T_ERR, cstart[31:0], 32'd0, 1'b1};
          halted_next = 1'b1;
          phase_next = P_IDLE;
          clen_next = '0;
        end else if (phase != P_IDLE) begin
          n = 2'd2;
          s = cstart + clen;
          e0 = '{bt, cstart[31:0], clen[31:0], 1'b0};
          e1 = '{T_END, s[31:0], 32'd0, 1'b1};
          cstart_next = s;
          clen_next = '0;
          phase_next = P_IDLE;
          cand_next = '1;
          npos_next = '0;
        end else begin
          n = 2'd1;
          e0 = '{T_END, cstart[31:0], 32'd0, 1'b1};
        end
      end else if (in_ch.mode == MODE_CHAR && !halted) begin
        if (phase != P_IDLE) begin
          used = 1'b1;
          unique case (phase)
            P_SPACES: used = c == 21'h20 || c == 21'h09;
            P_CR: begin
              used = c == 21'h0A;
              fin = used;
              ft = T_EOL;
            end
            P_STR: begin
              if (c == 21'h5C) p = P_STR_ESC;
              else if (c == 21'h22) begin
                fin = 1'b1;
                ft = T_STRING;
              end
            end
            P_STR_ESC: begin
              used = c == 21'h22 || c == 21'h5C || c == 21'h6E || c == 21'h72;
              if (used) p = P_STR;
            end
            P_REG_DOLLAR: begin
              if (c == 21'h30) begin
                fin = 1'b1;
                ft = T_REG;
              end else if (dg) p = P_REG_DIGITS;
              else if (ns) p = P_REG_NAME;
              else used = 1'b0;
            end
            P_REG_DIGITS: used = dg;
            P_REG_NAME: used = nc;
            P_NAME: begin
              used = nc;
              if (nc) begin
                cand_next = kw_adv;
                if (npos != 5'd31) npos_next = npos + 5'd1;
              end
            end
            P_INT: begin
              if (c == 21'h2E) p = P_FRAC;
              else used = dg;
            end
            P_FRAC: begin
              if (c == 21'h65 || c == 21'h45) p = P_EXP_MARK;
              else used = dg;
            end
            P_EXP_MARK: begin
              if (c == 21'h2B || c == 21'h2D) p = P_EXP_SIGN;
              else if (dg) p = P_EXP_DIGITS;
              else used = 1'b0;
            end
            P_EXP_SIGN: begin
              used = dg;
              if (dg) p = P_EXP_DIGITS;
            end
            P_EXP_DIGITS: used = dg;
            P_SLASH: begin
              if (c == 21'h2A) p = P_ML_BODY;
              else if (c == 21'h2F) p = P_SL_BODY;
              else used = 1'b0;
            end
            P_ML_BODY: if (c == 21'h2A) p = P_ML_STAR;
            P_ML_STAR: begin
              if (c == 21'h2F) begin
                fin = 1'b1;
                ft = T_MLC;
              end else if (c != 21'h2A) p = P_ML_BODY;
            end
            P_SL_BODY: used = c != 21'h0D && c != 21'h0A;
            default: used = 1'b0;
          endcase
          if (used) begin
            l = clen + ofs_t'(b);
            phase_next = p;
            clen_next = l;
            if (fin) begin
              n = 2'd1;
              e0 = '{ft, cstart[31:0], l[31:0], 1'b1};
              cstart_next = cstart + l;
              clen_next = '0;
              phase_next = P_IDLE;
              cand_next = '1;
              npos_next = '0;
            end
          end else if (!bok) begin
            err = 1'b1;
            n = 2'd1;
            e0 = '{T_ERR, cstart[31:0], 32'd0, 1'b1};
            halted_next = 1'b1;
            phase_next = P_IDLE;
            clen_next = '0;
          end else begin
            n = 2'd1;
            e0 = '{bt, cstart[31:0], clen[31:0], 1'b1};
            s = cstart + clen;
            cstart_next = s;
            cand_next = '1;
            npos_next = '0;
          end
        end
        if (!used && !err) begin
          tok_t t;
          logic emit_t;
          emit_t = 1'b0;
          t = '{T_ERR, s[31:0], 32'(b), 1'b1};
          clen_next = ofs_t'(b);
          phase_next = P_IDLE;
          unique case (c)
            21'h20, 21'h09: phase_next = P_SPACES;
            21'h0D: phase_next = P_CR;
            21'h0A: begin emit_t = 1'b1; t.token_type = T_EOL; end
            21'h3D: begin emit_t = 1'b1; t.token_type = T_EQ; end
            21'h2E: begin emit_t = 1'b1; t.token_type = T_PERIOD; end
            21'h3A: begin emit_t = 1'b1; t.token_type = T_COLON; end
            21'h2C: begin emit_t = 1'b1; t.token_type = T_COMMA; end
            21'h7B: begin emit_t = 1'b1; t.token_type = T_LCURLY; end
            21'h7D: begin emit_t = 1'b1; t.token_type = T_RCURLY; end
            21'h28: begin emit_t = 1'b1; t.token_type = T_LPAREN; end
            21'h29: begin emit_t = 1'b1; t.token_type = T_RPAREN; end
            21'h22: phase_next = P_STR;
            21'h24: phase_next = P_REG_DOLLAR;
            21'h2F: phase_next = P_SLASH;
            default: begin
              if (ns) begin
                phase_next = P_NAME;
                cand_next = kw_st;
                npos_next = 5'd1;
              end else if (dg) phase_next = P_INT;
              else begin
                emit_t = 1'b1;
                t.token_length = 32'd0;
                halted_next = 1'b1;
                clen_next = '0;
              end
            end
          endcase
          if (emit_t) begin
            if (t.token_type != T_ERR) begin
              cstart_next = s + ofs_t'(b);
              clen_next = '0;
            end else begin
              cstart_next = s;
            end
            if (n == 2'd1) begin
              e0.last = 1'b0;
              e1 = t;
              n = 2'd2;
            end else begin
              e0 = t;
              n = 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cand <= '1;
      npos <= '0;
      cstart <= '0;
      clen <= '0;
      halted <= 1'b0;
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (acc) begin
        phase <= phase_next;
        cand <= cand_next;
        npos <= npos_next;
        cstart <= cstart_next;
        clen <= clen_next;
        halted <= halted_next;
        v0 <= n != 2'd0;
        v1 <= n == 2'd2;
        r0 <= e0;
        r1 <= e1;
      end else if (out_ch.valid && out_ch.ready) begin
        v0 <= v1;
        v1 <= 1'b0;
        r0 <= r1;
      end
    end
  end

  assign out_ch.valid = v0;
  assign out_ch.token_type = r0.token_type;
  assign out_ch.token_start = r0.token_start;
  assign out_ch.token_length = r0.token_length;
  assign out_ch.last = r0.last;

  `ALT_ASSERT_IMP(a_second_needs_first, v1, v0, "second result without first")
  `ALT_ASSERT_IMP(a_no_accept_when_two, v1, !in_ch.ready, "accept while two results held")
  `ALT_ASSERT_IMP(a_halted_idle, halted, phase == P_IDLE, "halted outside idle")
  `ALT_ASSERT_NEXT(a_restart_clears, acc && in_ch.mode == MODE_RESTART,
                   !halted && !v0 && phase == P_IDLE, "restart left state")

endmodule

@@ rtl/alt_kw_match.sv @@
// keyword candidate mask update and keyword lookup
module alt_kw_match
  import alt_pkg::*;
(
  input  kw_mask_t    cand,
  input  logic [4:0]  pos,
  input  logic [20:0] c,
  output kw_mask_t    cand_next,
  output logic [5:0]  kw_type
);

  always_comb begin
    cand_next = '0;
    for (int k = 0; k < NumKeywords; k++) begin
      if (cand[k] && pos < 5'(KwWidth) && kw_char(k, 32'(pos)) != 8'd0
          && {13'd0, kw_char(k, 32'(pos))} == c) begin
        cand_next[k] = 1'b1;
      end
    end
  end

  always_comb begin
    kw_type = T_NAME;
    if (pos < 5'(KwWidth)) begin
      for (int k = NumKeywords - 1; k >= 0; k--) begin
        if (cand[k] && kw_char(k, 32'(pos)) == 8'd0) begin
          kw_type = T_KW0 + 6'((k < 34) ? k : 33);
        end
      end
    end
  end

endmodule

@@ verif/tokenizer_scoreboard.sv @@
// scoreboard class: token predictor and expected-token queue for the tokenizer
import alt_pkg::*;

class tok_scoreboard;
  phase_t phase;
  kw_mask_t cands;
  int unsigned name_pos;
  ofs_t cur_start;
  ofs_t cur_len;
  bit halted;
  tok_t pending[$];
  int unsigned errors;

  function new();
    errors = 0;
    clear_state();
  endfunction

  function void clear_state();
    phase = P_IDLE;
    cands = '1;
    name_pos = 0;
    cur_start = '0;
    cur_len = '0;
    halted = 0;
  endfunction

  function string kw_str(int unsigned k);
    string s;
    s = "";
    for (int unsigned p = 0; p < KwWidth; p++) begin
      if (kw_char(k, p) == 8'd0) break;
      s = {s, string'(kw_char(k, p))};
    end
    return s;
  endfunction

  function void kw_step(logic [20:0] c);
    kw_mask_t keep;
    string s;
    keep = '0;
    for (int unsigned k = 0; k < NumKeywords; k++) begin
      s = kw_str(k);
      if (cands[k] && name_pos < s.len() && s[name_pos] == c) keep[k] = 1'b1;
    end
    cands = keep;
    if (name_pos < 31) name_pos++;
  endfunction

  function logic [5:0] name_type();
    string s;
    if (name_pos >= KwWidth) return T_NAME;
    for (int unsigned k = 0; k < NumKeywords; k++) begin
      s = kw_str(k);
      if (cands[k] && s.len() == name_pos) return T_KW0 + 6'(k < 34 ? k : 33);
    end
    return T_NAME;
  endfunction

  function logic [2:0] nbytes(logic [20:0] c);
    if (c < 21'h80) return 3'd1;
    if (c < 21'h800) return 3'd2;
    if (c < 21'h10000) return 3'd3;
    return 3'd4;
  endfunction

  function bit is_dig(logic [20:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit is_nstart(logic [20:0] c);
    return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function void push(logic [5:0] t, ofs_t s, ofs_t l);
    tok_t x;
    x.token_type = t;
    x.token_start = s[31:0];
    x.token_length = l[31:0];
    x.last = 1'b0;
    pending.push_back(x);
  endfunction

  function void finish(logic [5:0] t);
    push(t, cur_start, cur_len);
    cur_start = cur_start + cur_len;
    cur_len = '0;
    phase = P_IDLE;
    cands = '1;
    name_pos = 0;
  endfunction

  function void fail();
    push(T_ERR, cur_start, '0);
    halted = 1;
    phase = P_IDLE;
    cur_len = '0;
  endfunction

  function int boundary();
    case (phase)
      P_SPACES: return T_SPACES;
      P_CR: return T_EOL;
      P_REG_DIGITS, P_REG_NAME: return T_REG;
      P_NAME: return name_type();
      P_INT: return T_INT;
      P_FRAC, P_EXP_DIGITS: return T_REAL;
      P_SL_BODY: return T_SLC;
      default: return -1;
    endcase
  endfunction

  // 0 joins, 1 joins and completes, 2 does not belong
  function int absorb(logic [20:0] c, output logic [5:0] t);
    t = T_ERR;
    case (phase)
      P_SPACES: return (c == " " || c == 9) ? 0 : 2;
      P_CR: begin
        if (c == 10) begin t = T_EOL; return 1; end
        return 2;
      end
      P_STR: begin
        if (c == "\\") begin phase = P_STR_ESC; return 0; end
        if (c == 34) begin t = T_STRING; return 1; end
        return 0;
      end
      P_STR_ESC: begin
        if (c == 34 || c == "\\" || c == "n" || c == "r") begin
          phase = P_STR;
          return 0;
        end
        return 2;
      end
      P_REG_DOLLAR: begin
        if (c == "0") begin t = T_REG; return 1; end
        if (c >= "1" && c <= "9") begin phase = P_REG_DIGITS; return 0; end
        if (is_nstart(c)) begin phase = P_REG_NAME; return 0; end
        return 2;
      end
      P_REG_DIGITS: return is_dig(c) ? 0 : 2;
      P_REG_NAME: return (is_nstart(c) || is_dig(c)) ? 0 : 2;
      P_NAME: begin
        if (is_nstart(c) || is_dig(c)) begin kw_step(c); return 0; end
        return 2;
      end
      P_INT: begin
        if (is_dig(c)) return 0;
        if (c == ".") begin phase = P_FRAC; return 0; end
        return 2;
      end
      P_FRAC: begin
        if (is_dig(c)) return 0;
        if (c == "e" || c == "E") begin phase = P_EXP_MARK; return 0; end
        return 2;
      end
      P_EXP_MARK: begin
        if (c == "+" || c == "-") begin phase = P_EXP_SIGN; return 0; end
        if (is_dig(c)) begin phase = P_EXP_DIGITS; return 0; end
        return 2;
      end
      P_EXP_SIGN: begin
        if (is_dig(c)) begin phase = P_EXP_DIGITS; return 0; end
        return 2;
      end
      P_EXP_DIGITS: return is_dig(c) ? 0 : 2;
      P_SLASH: begin
        if (c == "*") begin phase = P_ML_BODY; return 0; end
        if (c == "/") begin phase = P_SL_BODY; return 0; end
        return 2;
      end
      P_ML_BODY: begin
        if (c == "*") phase = P_ML_STAR;
        return 0;
      end
      P_ML_STAR: begin
        if (c == "/") begin t = T_MLC; return 1; end
        if (c != "*") phase = P_ML_BODY;
        return 0;
      end
      P_SL_BODY: return (c != 13 && c != 10) ? 0 : 2;
      default: return 2;
    endcase
  endfunction

  function void begin_token(logic [20:0] c, ofs_t b);
    cur_len = b;
    case (c)
      " ", 9: phase = P_SPACES;
      13: phase = P_CR;
      10: finish(T_EOL);
      "=": finish(T_EQ);
      ".": finish(T_PERIOD);
      ":": finish(T_COLON);
      ",": finish(T_COMMA);
      "{": finish(T_LCURLY);
      "}": finish(T_RCURLY);
      "(": finish(T_LPAREN);
      ")": finish(T_RPAREN);
      34: phase = P_STR;
      "$": phase = P_REG_DOLLAR;
      "/": phase = P_SLASH;
      default: begin
        if (is_nstart(c)) begin
          cands = '1;
          name_pos = 0;
          kw_step(c);
          phase = P_NAME;
        end else if (is_dig(c)) begin
          phase = P_INT;
        end else begin
          fail();
        end
      end
    endcase
  endfunction

  function void note_input(logic [1:0] mode, logic [20:0] c);
    int n0;
    int r;
    int bt;
    logic [5:0] t;
    ofs_t b;
    bit used;
    n0 = pending.size();
    if (mode == MODE_RESTART) begin
      clear_state();
      return;
    end
    if (mode == MODE_IGNORE || halted) return;
    if (mode == MODE_END) begin
      bt = 0;
      if (phase != P_IDLE) begin
        bt = boundary();
        if (bt < 0) fail();
        else finish(6'(bt));
      end
      if (bt >= 0) push(T_END, cur_start, '0);
    end else begin
      b = ofs_t'(nbytes(c));
      used = 0;
      bt = 0;
      if (phase != P_IDLE) begin
        r = absorb(c, t);
        if (r == 0) begin
          cur_len = cur_len + b;
          used = 1;
        end else if (r == 1) begin
          cur_len = cur_len + b;
          finish(t);
          used = 1;
        end else begin
          bt = boundary();
          if (bt < 0) begin
            fail();
            used = 1;
          end else begin
            finish(6'(bt));
          end
        end
      end
      if (!used) begin_token(c, b);
    end
    if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
  endfunction

  function void check_token(tok_t got);
    tok_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected token %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("token mismatch: expected %p actual %p", want, got);
    end
  endfunction
endclass

@@ verif/testbench.sv @@
// testbench top: drives characters and end, restart and ignore items into the tokenizer and checks the tokens
module testbench;
  import alt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 5000;

  logic clk;
  logic rst;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned quiet_cycles;
  int unsigned ndone;
  tok_scoreboard tokens_sb;
  alt_in_if in_ch ();
  alt_out_if out_ch ();

  assembly_language_tokenizer DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    tokens_sb = new();
    in_ch.valid = 0;
    in_ch.mode = MODE_CHAR;
    in_ch.code_point = '0;
    src_idle_pct = 30;
    snk_idle_pct = 65;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      tokens_sb.check_token({out_ch.token_type, out_ch.token_start,
                             out_ch.token_length, out_ch.last});
    end
    if (!rst && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= StallLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [20:0] cp);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.code_point <= cp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tokens_sb.note_input(mode, cp);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(MODE_CHAR, 21'(s[i]));
  endtask

  function automatic logic [20:0] pick_char();
    string pool;
    int unsigned r;
    pool = "abcdefxyzEIT_0123456789 \t\r\n=.:,{}()\"\\$/*+-eE";
    r = $urandom_range(99);
    if (r < 85) return 21'(pool[$urandom_range(pool.len() - 1)]);
    if (r < 90) return 21'($urandom_range(21'h1FFFFF));
    if (r < 94) return 21'($urandom_range(21'h7FF, 21'h80));
    if (r < 97) return 21'($urandom_range(21'hFFFF, 21'h800));
    return 21'($urandom_range(21'h10FFFF, 21'h10000));
  endfunction

  task automatic random_phase(input int unsigned items);
    string frags[$];
    string f;
    frags = '{"class", "isGreaterThanOrEqualTo", "jumpIfTrue", "true", "false", "set",
              "void", "or", "isLowerThanOrEqualTo", "$0", "$17", "$reg_1", "12.5e-3",
              "3.", "7.E+9", "\"a\\n\\\"b\"", "// note\r\n", "/* x ** y */", " \t ",
              "\r\n", "\n", "x_9", "abcdefghijklmnopqrstuvwxyz12", "{", ")", "=", ","};
    for (int unsigned n = 0; n < items; n++) begin
      if ($urandom_range(99) < 60) begin
        f = frags[$urandom_range(frags.size() - 1)];
        send_text(f);
        n += f.len();
      end else if ($urandom_range(99) < 5) begin
        send_item(MODE_END, 21'($urandom));
      end else if ($urandom_range(99) < 4) begin
        send_item($urandom_range(99) < 80 ? MODE_RESTART : MODE_IGNORE, 21'($urandom));
      end else begin
        send_item(MODE_CHAR, pick_char());
      end
      if (tokens_sb.halted && $urandom_range(99) < 70) send_item(MODE_RESTART, '0);
    end
  endtask

  initial begin
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_text("class x=$0 $12,$ab{1.5e+3}(2.)\"s\\\\\"\r\n\r");
    send_text("//c\n/*a*b*/ \tisGreaterThanOrEqualTo true false ");
    send_item(MODE_END, '0);
    send_item(MODE_CHAR, 21'h7F);
    send_item(MODE_CHAR, 21'h1FFFFF);
    send_item(MODE_CHAR, 21'h41);
    send_item(MODE_RESTART, '0);
    send_text("ab");
    send_item(MODE_CHAR, 21'h800);
    send_item(MODE_RESTART, '0);
    send_text("\"x\\q");
    send_item(MODE_RESTART, '0);
    send_text("1.e");
    send_item(MODE_END, '0);
    send_item(MODE_RESTART, '0);
    send_item(MODE_IGNORE, 21'h1FFFFF);
    send_text("\"");
    send_item(MODE_CHAR, 21'hFFFF);
    send_item(MODE_CHAR, 21'h10000);
    send_item(MODE_END, '0);
    send_item(MODE_RESTART, '0);
    random_phase(550);
    src_idle_pct = 65;
    snk_idle_pct = 30;
    random_phase(550);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_phase(550);
    send_item(MODE_END, '0);
    in_ch.valid <= 1'b0;
    ndone = 0;
    while (tokens_sb.pending.size() != 0 && ndone < 100000) begin
      @(posedge clk);
      ndone++;
    end
    repeat (20) @(posedge clk);
    if (tokens_sb.errors == 0 && tokens_sb.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
